// File: hdl/ptb_pkg.sv
`default_nettype none

package ptb_pkg;

  localparam int CHANNELS_DEF = 8;
  localparam int MAX_FIRES    = 8;

  typedef enum logic [3:0] {
    CMD_TICK       = 4'd0,
    CMD_ADD        = 4'd1,
    CMD_DELETE     = 4'd2,
    CMD_PAUSE      = 4'd3,
    CMD_RESUME     = 4'd4,
    CMD_TOGGLE     = 4'd5,
    CMD_RESET      = 4'd6,
    CMD_RESET_ALL  = 4'd7,
    CMD_SET_PERIOD = 4'd8
  } ptb_cmd_e;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_FULL     = 2'd1,
    STS_INACTIVE = 2'd2
  } ptb_status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_MUL,
    ST_CMP,
    ST_END,
    ST_ADD,
    ST_EXEC,
    ST_RESP
  } ptb_state_e;

  typedef struct packed {
    logic        mul_en;
    logic        inc;
    logic [31:0] start;
    logic [31:0] count;
    logic [23:0] period;
    logic [31:0] elapsed;
    logic [31:0] now;
  } ptb_alu_in_t;

  typedef struct packed {
    logic        gt;
    logic [31:0] pause_elapsed;
    logic [31:0] resume_start;
  } ptb_alu_out_t;

endpackage

`default_nettype wire

// File: hdl/ptb_alu.sv
`default_nettype none

module ptb_alu (
  input  wire logic               clk_i,
  input  wire ptb_pkg::ptb_alu_in_t alu_i,
  output ptb_pkg::ptb_alu_out_t   alu_o
);

  logic [32:0] mul_b;
  logic [56:0] prod_w;
  logic [56:0] prod_q;
  logic [56:0] base;

  assign mul_b  = {1'b0, alu_i.count} + {32'd0, alu_i.inc};
  assign prod_w = alu_i.period * mul_b;

  always_ff @(posedge clk_i) begin
    if (alu_i.mul_en) begin
      prod_q <= prod_w;
    end
  end

  assign base = {25'd0, alu_i.start} + prod_q;

  always_comb begin
    alu_o.gt            = ({25'd0, alu_i.now} > base);
    alu_o.pause_elapsed = alu_o.gt ? (alu_i.now - base[31:0]) : 32'd0;
    alu_o.resume_start  = (alu_i.now >= alu_i.elapsed) ? (alu_i.now - alu_i.elapsed) : 32'd0;
  end

endmodule

`default_nettype wire

// File: hdl/periodic_timer_bank_unit.sv
`default_nettype none

// Bank of CHANNELS periodic timers driven by a request stream.
// Input channel: in_valid_i / in_stall_o with cmd_i, channel_i, period_i, now_i.
// A request is taken when in_valid_i is high and in_stall_o is low; in_stall_o is
// high from the cycle after acceptance until the last result has been registered.
// Output channel: out_valid_o / out_stall_i with status_o, channel_out_o, fired_o,
// last_o; one register holds the result while the receiver stalls, and the
// sequencer waits for it to drain before placing the next one.
// Add tests one channel per cycle until it finds a free one or reaches the last;
// pause, resume and toggle on an active channel also read the channel memory and
// pass through the shared unit; other channel commands go from decode to the result.
// A tick scans every channel; each active, unpaused channel reads the channel
// memory, multiplies in the shared unit and compares, and a firing can wait there
// while the output register is still held by a stalled receiver.
// Reset clears all channel flags, the sequencer and the output valid flag; channel
// memory contents are only read after an add has written them.
// Firing results carry last_o on the final one; a tick with no firing gives one
// result with fired_o low.

module periodic_timer_bank_unit #(
  parameter int CHANNELS = ptb_pkg::CHANNELS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [3:0]  cmd_i,
  input  wire logic [2:0]  channel_i,
  input  wire logic [23:0] period_i,
  input  wire logic [31:0] now_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic [2:0]       channel_out_o,
  output logic             fired_o,
  output logic             last_o
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CHE_W = (IDX_W > 3) ? IDX_W : 3;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CHANNELS - 1);

  ptb_pkg::ptb_state_e state_q, state_d;

  logic [3:0]  cmd_q;
  logic [2:0]  ch_q;
  logic [23:0] per_q;
  logic [31:0] now_q;

  logic [IDX_W-1:0] idx_q, idx_d;
  logic [3:0]       nfire_q, nfire_d;
  logic             pend_v_q, pend_v_d;
  logic [IDX_W-1:0] pend_ch_q, pend_ch_d;
  logic [1:0]       res_sts_q, res_sts_d;
  logic [2:0]       res_ch_q, res_ch_d;

  logic [CHANNELS-1:0] active_q, active_d;
  logic [CHANNELS-1:0] paused_q, paused_d;
  logic [CHANNELS-1:0] rstp_q, rstp_d;

  logic       out_valid_q, out_valid_d;
  logic       out_ld;
  logic [1:0] out_sts_d, out_sts_q;
  logic [2:0] out_ch_d, out_ch_q;
  logic       out_fired_d, out_fired_q;
  logic       out_last_d, out_last_q;
  logic       out_free;

  logic [31:0] start_mem   [CHANNELS];
  logic [31:0] count_mem   [CHANNELS];
  logic [23:0] period_mem  [CHANNELS];
  logic [31:0] elapsed_mem [CHANNELS];

  logic [31:0] rd_start_q, rd_count_q, rd_elapsed_q;
  logic [23:0] rd_period_q;

  logic [IDX_W-1:0] mem_addr;
  logic             mem_rd;
  logic             we_start, we_count, we_period, we_elapsed;
  logic [31:0]      wd_start, wd_count, wd_elapsed;
  logic [23:0]      wd_period;

  logic [CHE_W-1:0] ch_ext, idx_ext, pend_ext;
  logic [IDX_W-1:0] ch_idx;
  logic             ch_ok;
  logic             use_ch;
  logic             go_resume;
  logic             accept;

  ptb_pkg::ptb_alu_in_t  alu_in;
  ptb_pkg::ptb_alu_out_t alu_out;

  ptb_alu u_alu (
    .clk_i (clk_i),
    .alu_i (alu_in),
    .alu_o (alu_out)
  );

  assign ch_ext   = CHE_W'(ch_q);
  assign ch_idx   = ch_ext[IDX_W-1:0];
  assign idx_ext  = CHE_W'(idx_q);
  assign pend_ext = CHE_W'(pend_ch_q);
  assign ch_ok    = ({29'd0, ch_q} < 32'(CHANNELS)) && active_q[ch_idx];
  assign use_ch   = (cmd_q != ptb_pkg::CMD_TICK) && (cmd_q != ptb_pkg::CMD_ADD);
  assign mem_addr = use_ch ? ch_idx : idx_q;
  assign go_resume = (cmd_q == ptb_pkg::CMD_RESUME) ||
                     ((cmd_q == ptb_pkg::CMD_TOGGLE) && paused_q[ch_idx]);

  assign in_stall_o = (state_q != ptb_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    alu_in.mul_en  = (state_q == ptb_pkg::ST_MUL);
    alu_in.inc     = (cmd_q == ptb_pkg::CMD_TICK);
    alu_in.start   = rd_start_q;
    alu_in.count   = rd_count_q;
    alu_in.period  = rd_period_q;
    alu_in.elapsed = rd_elapsed_q;
    alu_in.now     = now_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ptb_pkg::ST_IDLE;
      idx_q       <= '0;
      nfire_q     <= '0;
      pend_v_q    <= 1'b0;
      active_q    <= '0;
      paused_q    <= '0;
      rstp_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      nfire_q     <= nfire_d;
      pend_v_q    <= pend_v_d;
      active_q    <= active_d;
      paused_q    <= paused_d;
      rstp_q      <= rstp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
      ch_q  <= channel_i;
      per_q <= period_i;
      now_q <= now_i;
    end
    pend_ch_q <= pend_ch_d;
    res_sts_q <= res_sts_d;
    res_ch_q  <= res_ch_d;
    if (out_ld) begin
      out_sts_q   <= out_sts_d;
      out_ch_q    <= out_ch_d;
      out_fired_q <= out_fired_d;
      out_last_q  <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_rd) begin
      rd_start_q   <= start_mem[mem_addr];
      rd_count_q   <= count_mem[mem_addr];
      rd_period_q  <= period_mem[mem_addr];
      rd_elapsed_q <= elapsed_mem[mem_addr];
    end
    if (we_start) begin
      start_mem[mem_addr] <= wd_start;
    end
    if (we_count) begin
      count_mem[mem_addr] <= wd_count;
    end
    if (we_period) begin
      period_mem[mem_addr] <= wd_period;
    end
    if (we_elapsed) begin
      elapsed_mem[mem_addr] <= wd_elapsed;
    end
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    nfire_d     = nfire_q;
    pend_v_d    = pend_v_q;
    pend_ch_d   = pend_ch_q;
    res_sts_d   = res_sts_q;
    res_ch_d    = res_ch_q;
    active_d    = active_q;
    paused_d    = paused_q;
    rstp_d      = rstp_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_ld      = 1'b0;
    out_sts_d   = ptb_pkg::STS_OK;
    out_ch_d    = 3'd0;
    out_fired_d = 1'b0;
    out_last_d  = 1'b0;
    mem_rd      = 1'b0;
    we_start    = 1'b0;
    we_count    = 1'b0;
    we_period   = 1'b0;
    we_elapsed  = 1'b0;
    wd_start    = now_q;
    wd_count    = 32'd0;
    wd_period   = per_q;
    wd_elapsed  = 32'd0;

    unique case (state_q)
      ptb_pkg::ST_IDLE: begin
        if (accept) begin
          idx_d   = '0;
          state_d = ptb_pkg::ST_DECODE;
        end
      end

      ptb_pkg::ST_DECODE: begin
        res_sts_d = ptb_pkg::STS_OK;
        res_ch_d  = 3'd0;
        state_d   = ptb_pkg::ST_RESP;
        unique case (cmd_q)
          ptb_pkg::CMD_TICK: begin
            nfire_d  = '0;
            pend_v_d = 1'b0;
            state_d  = ptb_pkg::ST_SCAN;
          end
          ptb_pkg::CMD_ADD: begin
            state_d = ptb_pkg::ST_ADD;
          end
          ptb_pkg::CMD_RESET_ALL: begin
            rstp_d = rstp_q | active_q;
          end
          ptb_pkg::CMD_DELETE, ptb_pkg::CMD_PAUSE, ptb_pkg::CMD_RESUME,
          ptb_pkg::CMD_TOGGLE, ptb_pkg::CMD_RESET, ptb_pkg::CMD_SET_PERIOD: begin
            if (!ch_ok) begin
              res_sts_d = ptb_pkg::STS_INACTIVE;
            end else if (cmd_q == ptb_pkg::CMD_DELETE) begin
              active_d[ch_idx] = 1'b0;
              paused_d[ch_idx] = 1'b0;
              rstp_d[ch_idx]   = 1'b0;
            end else if (cmd_q == ptb_pkg::CMD_RESET) begin
              rstp_d[ch_idx] = 1'b1;
            end else if (cmd_q == ptb_pkg::CMD_SET_PERIOD) begin
              we_period = 1'b1;
            end else begin
              mem_rd  = 1'b1;
              state_d = ptb_pkg::ST_MUL;
            end
          end
          default: begin
          end
        endcase
      end

      ptb_pkg::ST_SCAN: begin
        if (rstp_q[idx_q]) begin
          rstp_d[idx_q] = 1'b0;
          we_start      = 1'b1;
          we_count      = 1'b1;
          we_elapsed    = 1'b1;
          if (idx_q == IDX_LAST) begin
            state_d = ptb_pkg::ST_END;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end else if (active_q[idx_q] && !paused_q[idx_q] && (nfire_q < 4'(ptb_pkg::MAX_FIRES))) begin
          mem_rd  = 1'b1;
          state_d = ptb_pkg::ST_MUL;
        end else if (idx_q == IDX_LAST) begin
          state_d = ptb_pkg::ST_END;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      ptb_pkg::ST_MUL: begin
        state_d = (cmd_q == ptb_pkg::CMD_TICK) ? ptb_pkg::ST_CMP : ptb_pkg::ST_EXEC;
      end

      ptb_pkg::ST_CMP: begin
        if (!alu_out.gt || !pend_v_q || out_free) begin
          if (alu_out.gt) begin
            if (pend_v_q) begin
              out_ld      = 1'b1;
              out_valid_d = 1'b1;
              out_sts_d   = ptb_pkg::STS_OK;
              out_ch_d    = pend_ext[2:0];
              out_fired_d = 1'b1;
              out_last_d  = 1'b0;
            end
            we_count  = 1'b1;
            wd_count  = (rd_count_q == 32'hFFFF_FFFF) ? rd_count_q : rd_count_q + 32'd1;
            nfire_d   = nfire_q + 4'd1;
            pend_v_d  = 1'b1;
            pend_ch_d = idx_q;
          end
          if (idx_q == IDX_LAST) begin
            state_d = ptb_pkg::ST_END;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ptb_pkg::ST_SCAN;
          end
        end
      end

      ptb_pkg::ST_END: begin
        if (out_free) begin
          out_ld      = 1'b1;
          out_valid_d = 1'b1;
          out_sts_d   = ptb_pkg::STS_OK;
          out_ch_d    = pend_v_q ? pend_ext[2:0] : 3'd0;
          out_fired_d = pend_v_q;
          out_last_d  = 1'b1;
          pend_v_d    = 1'b0;
          state_d     = ptb_pkg::ST_IDLE;
        end
      end

      ptb_pkg::ST_ADD: begin
        if (!active_q[idx_q]) begin
          active_d[idx_q] = 1'b1;
          paused_d[idx_q] = 1'b0;
          rstp_d[idx_q]   = 1'b0;
          we_start        = 1'b1;
          we_count        = 1'b1;
          we_period       = 1'b1;
          we_elapsed      = 1'b1;
          res_sts_d       = ptb_pkg::STS_OK;
          res_ch_d        = idx_ext[2:0];
          state_d         = ptb_pkg::ST_RESP;
        end else if (idx_q == IDX_LAST) begin
          res_sts_d = ptb_pkg::STS_FULL;
          res_ch_d  = 3'd0;
          state_d   = ptb_pkg::ST_RESP;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      ptb_pkg::ST_EXEC: begin
        if (go_resume) begin
          if (paused_q[ch_idx]) begin
            we_start         = 1'b1;
            wd_start         = alu_out.resume_start;
            we_count         = 1'b1;
            paused_d[ch_idx] = 1'b0;
          end
        end else begin
          we_elapsed       = 1'b1;
          wd_elapsed       = alu_out.pause_elapsed;
          paused_d[ch_idx] = 1'b1;
        end
        res_sts_d = ptb_pkg::STS_OK;
        res_ch_d  = 3'd0;
        state_d   = ptb_pkg::ST_RESP;
      end

      ptb_pkg::ST_RESP: begin
        if (out_free) begin
          out_ld      = 1'b1;
          out_valid_d = 1'b1;
          out_sts_d   = res_sts_q;
          out_ch_d    = res_ch_q;
          out_fired_d = 1'b0;
          out_last_d  = 1'b1;
          state_d     = ptb_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = ptb_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_sts_q;
  assign channel_out_o = out_ch_q;
  assign fired_o       = out_fired_q;
  assign last_o        = out_last_q;

  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ptb_pkg::ST_IDLE) |-> !pend_v_q)
    else $error("held firing left over in idle");

  a_fire_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nfire_q <= 4'(ptb_pkg::MAX_FIRES))
    else $error("firing count beyond cap");

  a_rstp_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rstp_q & ~active_q) == '0)
    else $error("reset pending on inactive channel");

  a_paused_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (paused_q & ~active_q) == '0)
    else $error("paused flag on inactive channel");

endmodule

`default_nettype wire

// File: bench/timer_bank_monitor.sv
`timescale 1ns / 1ps

module timer_bank_monitor
  import ptb_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_o,
  input  wire logic [3:0]  cmd_i,
  input  wire logic [2:0]  channel_i,
  input  wire logic [23:0] period_i,
  input  wire logic [31:0] now_i,
  input  wire logic        out_valid_o,
  input  wire logic        out_stall_i,
  input  wire logic [1:0]  status_o,
  input  wire logic [2:0]  channel_out_o,
  input  wire logic        fired_o,
  input  wire logic        last_o,
  output int               fail_count,
  output int               reports_owed,
  output int               req_count,
  output int               report_count,
  output int               fire_count
);

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] chan;
    logic       fired;
    logic       last;
  } timer_report_t;

  timer_report_t timer_reports_q[$];

  logic        ch_active [CHANNELS];
  logic        ch_paused [CHANNELS];
  logic        ch_restart[CHANNELS];
  logic [31:0] ch_start  [CHANNELS];
  logic [31:0] ch_count  [CHANNELS];
  logic [23:0] ch_period [CHANNELS];
  logic [31:0] ch_elapsed[CHANNELS];

  function automatic timer_report_t mk_report(logic [1:0] st, logic [2:0] ch, logic fi,
                                              logic la);
    timer_report_t r;
    r.status = st;
    r.chan   = ch;
    r.fired  = fi;
    r.last   = la;
    return r;
  endfunction

  function automatic void pause_channel(int c, logic [31:0] now);
    logic [63:0] base;
    logic [63:0] gap;
    base = 64'(ch_start[c]) + 64'(ch_period[c]) * 64'(ch_count[c]);
    gap  = (64'(now) <= base) ? 64'd0 : 64'(now) - base;
    ch_elapsed[c] = (gap > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : gap[31:0];
    ch_paused[c]  = 1'b1;
  endfunction

  function automatic void resume_channel(int c, logic [31:0] now);
    if (ch_paused[c]) begin
      ch_start[c]  = (now >= ch_elapsed[c]) ? now - ch_elapsed[c] : 32'd0;
      ch_count[c]  = 32'd0;
      ch_paused[c] = 1'b0;
    end
  endfunction

  // Apply one request to the channel state and queue the reports it owes.
  function automatic void step_timer_bank(logic [3:0] cmd, logic [2:0] ch, logic [23:0] per,
                                          logic [31:0] now);
    logic [63:0]         limit;
    logic [CHANNELS-1:0] fire_mask;
    int                  n;
    int                  k;
    int                  free_ch;
    fire_mask = '0;
    n         = 0;
    k         = 0;
    free_ch   = -1;
    case (cmd)
      CMD_TICK: begin
        for (int c = 0; c < CHANNELS; c++) begin
          if (ch_restart[c]) begin
            ch_start[c]   = now;
            ch_count[c]   = 32'd0;
            ch_elapsed[c] = 32'd0;
            ch_restart[c] = 1'b0;
          end else if (ch_active[c] && !ch_paused[c] && n < MAX_FIRES) begin
            limit = 64'(ch_start[c]) + 64'(ch_period[c]) * (64'(ch_count[c]) + 64'd1);
            if (64'(now) > limit) begin
              if (ch_count[c] != 32'hFFFF_FFFF) ch_count[c] = ch_count[c] + 32'd1;
              fire_mask[c] = 1'b1;
              n++;
            end
          end
        end
        if (n == 0) begin
          timer_reports_q.push_back(mk_report(STS_OK, 3'd0, 1'b0, 1'b1));
        end else begin
          for (int c = 0; c < CHANNELS; c++) begin
            if (fire_mask[c]) begin
              k++;
              timer_reports_q.push_back(mk_report(STS_OK, c[2:0], 1'b1, k == n));
            end
          end
        end
      end
      CMD_ADD: begin
        for (int c = CHANNELS - 1; c >= 0; c--) begin
          if (!ch_active[c]) free_ch = c;
        end
        if (free_ch < 0) begin
          timer_reports_q.push_back(mk_report(STS_FULL, 3'd0, 1'b0, 1'b1));
        end else begin
          ch_active[free_ch]  = 1'b1;
          ch_paused[free_ch]  = 1'b0;
          ch_restart[free_ch] = 1'b0;
          ch_start[free_ch]   = now;
          ch_count[free_ch]   = 32'd0;
          ch_period[free_ch]  = per;
          ch_elapsed[free_ch] = 32'd0;
          timer_reports_q.push_back(mk_report(STS_OK, free_ch[2:0], 1'b0, 1'b1));
        end
      end
      CMD_RESET_ALL: begin
        for (int c = 0; c < CHANNELS; c++) begin
          if (ch_active[c]) ch_restart[c] = 1'b1;
        end
        timer_reports_q.push_back(mk_report(STS_OK, 3'd0, 1'b0, 1'b1));
      end
      CMD_DELETE, CMD_PAUSE, CMD_RESUME, CMD_TOGGLE, CMD_RESET, CMD_SET_PERIOD: begin
        if (int'(ch) >= CHANNELS || !ch_active[int'(ch)]) begin
          timer_reports_q.push_back(mk_report(STS_INACTIVE, 3'd0, 1'b0, 1'b1));
        end else begin
          case (cmd)
            CMD_DELETE: begin
              ch_active[ch]  = 1'b0;
              ch_paused[ch]  = 1'b0;
              ch_restart[ch] = 1'b0;
            end
            CMD_PAUSE:  pause_channel(ch, now);
            CMD_RESUME: resume_channel(ch, now);
            CMD_TOGGLE: begin
              if (ch_paused[ch]) resume_channel(ch, now);
              else pause_channel(ch, now);
            end
            CMD_RESET: ch_restart[ch] = 1'b1;
            default:   ch_period[ch] = per;
          endcase
          timer_reports_q.push_back(mk_report(STS_OK, 3'd0, 1'b0, 1'b1));
        end
      end
      default: timer_reports_q.push_back(mk_report(STS_OK, 3'd0, 1'b0, 1'b1));
    endcase
  endfunction

  assign reports_owed = timer_reports_q.size();

  always @(posedge clk_i) begin
    timer_report_t want;
    if (!rst_ni) begin
      timer_reports_q.delete();
      fail_count   <= 0;
      req_count    <= 0;
      report_count <= 0;
      fire_count   <= 0;
      for (int c = 0; c < CHANNELS; c++) begin
        ch_active[c]  = 1'b0;
        ch_paused[c]  = 1'b0;
        ch_restart[c] = 1'b0;
        ch_start[c]   = 32'd0;
        ch_count[c]   = 32'd0;
        ch_period[c]  = 24'd0;
        ch_elapsed[c] = 32'd0;
      end
    end else begin
      if (out_valid_o && !out_stall_i) begin
        report_count <= report_count + 1;
        if (fired_o) fire_count <= fire_count + 1;
        if (timer_reports_q.size() == 0) begin
          $display("%0t: unexpected report status=%0d chan=%0d fired=%0b last=%0b",
                   $time, status_o, channel_out_o, fired_o, last_o);
          fail_count <= fail_count + 1;
        end else begin
          want = timer_reports_q.pop_front();
          if (want.status !== status_o || want.chan !== channel_out_o ||
              want.fired !== fired_o || want.last !== last_o) begin
            $display("%0t: report mismatch expected status=%0d chan=%0d fired=%0b last=%0b",
                     $time, want.status, want.chan, want.fired, want.last);
            $display("%0t:                 actual   status=%0d chan=%0d fired=%0b last=%0b",
                     $time, status_o, channel_out_o, fired_o, last_o);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        req_count <= req_count + 1;
        step_timer_bank(cmd_i, channel_i, period_i, now_i);
      end
    end
  end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ptb_pkg::*;

  localparam logic [3:0] CMD_SPARE_LO = 4'd9;
  localparam logic [3:0] CMD_SPARE_HI = 4'd15;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [3:0]  cmd_i       = 4'd0;
  logic [2:0]  channel_i   = 3'd0;
  logic [23:0] period_i    = 24'd0;
  logic [31:0] now_i       = 32'd0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [1:0]  status_o;
  logic [2:0]  channel_out_o;
  logic        fired_o;
  logic        last_o;

  int          fail_count;
  int          reports_owed;
  int          req_count;
  int          report_count;
  int          fire_count;
  int          idle_pct  = 0;
  int          stall_pct = 0;
  logic [31:0] wall_time = 32'd0;

  periodic_timer_bank_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .channel_i     (channel_i),
    .period_i      (period_i),
    .now_i         (now_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .channel_out_o (channel_out_o),
    .fired_o       (fired_o),
    .last_o        (last_o)
  );

  timer_bank_monitor u_monitor (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .channel_i     (channel_i),
    .period_i      (period_i),
    .now_i         (now_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .channel_out_o (channel_out_o),
    .fired_o       (fired_o),
    .last_o        (last_o),
    .fail_count    (fail_count),
    .reports_owed  (reports_owed),
    .req_count     (req_count),
    .report_count  (report_count),
    .fire_count    (fire_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= rst_ni && ($urandom_range(99) < stall_pct);
  end

  task automatic send_req(logic [3:0] cmd, logic [2:0] ch, logic [23:0] per, logic [31:0] now);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    channel_i  <= ch;
    period_i   <= per;
    now_i      <= now;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Mostly a forward-running clock with short periods so channels fire; some noise.
  task automatic random_request();
    logic [3:0]  cmd;
    logic [23:0] per;
    logic [31:0] now;
    int          r;
    r = $urandom_range(99);
    if (r < 40)      cmd = CMD_TICK;
    else if (r < 52) cmd = CMD_ADD;
    else if (r < 60) cmd = CMD_DELETE;
    else if (r < 68) cmd = CMD_PAUSE;
    else if (r < 75) cmd = CMD_RESUME;
    else if (r < 82) cmd = CMD_TOGGLE;
    else if (r < 88) cmd = CMD_RESET;
    else if (r < 91) cmd = CMD_RESET_ALL;
    else if (r < 97) cmd = CMD_SET_PERIOD;
    else             cmd = 4'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
    per = ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(30));
    if ($urandom_range(19) == 0) begin
      now = $urandom;
    end else begin
      wall_time = wall_time + 32'($urandom_range(40));
      now = wall_time;
    end
    send_req(cmd, 3'($urandom_range(7)), per, now);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_req(CMD_TICK, 3'd0, 24'd0, 32'd0);
    send_req(CMD_PAUSE, 3'd7, 24'd0, 32'd0);
    send_req(CMD_ADD, 3'd5, 24'd0, 32'd0);
    send_req(CMD_ADD, 3'd0, 24'hFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 1; i <= 6; i++) send_req(CMD_ADD, 3'd0, 24'(i), 32'd10);
    send_req(CMD_ADD, 3'd0, 24'd3, 32'd10);
    send_req(CMD_TICK, 3'd0, 24'd0, 32'd100);
    send_req(CMD_PAUSE, 3'd2, 24'd0, 32'd5);
    send_req(CMD_PAUSE, 3'd3, 24'd0, 32'hFFFF_FFFF);
    send_req(CMD_RESUME, 3'd3, 24'd0, 32'd7);
    send_req(CMD_RESUME, 3'd4, 24'd0, 32'd120);
    send_req(CMD_TOGGLE, 3'd4, 24'd0, 32'd120);
    send_req(CMD_TOGGLE, 3'd4, 24'd0, 32'd130);
    send_req(CMD_SET_PERIOD, 3'd5, 24'hFF_FFFF, 32'd0);
    send_req(CMD_RESET, 3'd6, 24'd0, 32'd0);
    send_req(CMD_TICK, 3'd0, 24'd0, 32'd200);
    send_req(CMD_RESET_ALL, 3'd0, 24'd0, 32'd0);
    send_req(CMD_TICK, 3'd0, 24'd0, 32'd300);
    send_req(CMD_TICK, 3'd7, 24'hFF_FFFF, 32'hFFFF_FFFF);
    send_req(CMD_DELETE, 3'd7, 24'd0, 32'd0);
    send_req(CMD_DELETE, 3'd7, 24'd0, 32'd0);
    send_req(CMD_SPARE_HI, 3'd7, 24'hFF_FFFF, 32'hFFFF_FFFF);

    wall_time = 32'd400;
    repeat (85) random_request();
    idle_pct = 60;
    repeat (100) random_request();
    idle_pct  = 0;
    stall_pct = 60;
    repeat (100) random_request();
    idle_pct  = 35;
    stall_pct = 35;
    repeat (100) random_request();
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (reports_owed != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("%0d requests sent under four flow-control phases", req_count);
    $display("%0d reports checked, %0d of them channel firings", report_count, fire_count);
    if (fail_count == 0) begin
      $display("[periodic_timer_bank_unit] OK");
    end else begin
      $display("[periodic_timer_bank_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d reports outstanding", reports_owed);
    $display("[periodic_timer_bank_unit] ERROR");
    $finish;
  end

endmodule
